// ===== rtl/adc_moving_average_unit_macros.svh =====
// Assertion macros shared by the moving-average RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef ADC_MOVING_AVERAGE_UNIT_MACROS_SVH
`define ADC_MOVING_AVERAGE_UNIT_MACROS_SVH

// Combinational invariant, checked at every clock edge outside reset.
`define AMA_ASSERT_HOLD(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define AMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition implies a consequence in the same cycle.
`define AMA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/adc_ma_pkg.sv =====
// Package for the ADC moving-average unit: sizes, reset values,
// divider request/response types and the window length clamp.
// No dependencies.
`timescale 1ns / 1ps

package adc_ma_pkg;

    localparam int WINDOW_MAX    = 64;
    localparam int SAMPLE_BITS   = 12;
    localparam int CFG_BITS      = 7;
    localparam int IDX_BITS      = $clog2(WINDOW_MAX);
    localparam int LEN_BITS      = $clog2(WINDOW_MAX + 1);
    localparam int SUM_BITS      = SAMPLE_BITS + IDX_BITS;
    localparam int FRAC_BITS     = 8;
    localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
    localparam int AVG_BITS      = 20;
    localparam int DIV_STEPS     = DIVIDEND_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_BITS-1:0] WINDOW_LEN_RESET = CFG_BITS'(16);
    localparam logic [SUM_BITS-1:0] SUM_MAX =
        SUM_BITS'(WINDOW_MAX * ((1 << SAMPLE_BITS) - 1));

    // Request to the divider.
    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [LEN_BITS-1:0]      divisor;
    } div_req_t;

    // Response from the divider.
    typedef struct packed {
        logic                     done;
        logic                     busy;
        logic [DIVIDEND_BITS-1:0] quotient;
    } div_rsp_t;

    // Clamp the programmed window length to 1 .. WINDOW_MAX.
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [CFG_BITS-1:0] wl);
        logic [LEN_BITS-1:0] len;
        if (wl == '0) begin
            len = LEN_BITS'(1);
        end else if (int'(wl) > WINDOW_MAX) begin
            len = LEN_BITS'(WINDOW_MAX);
        end else begin
            len = LEN_BITS'(wl);
        end
        return len;
    endfunction

endpackage

// ===== rtl/adc_ma_ring.sv =====
// Sample ring storage: one write port and one registered read port.
// Depends on adc_ma_pkg for the depth and sample width.
`timescale 1ns / 1ps

module adc_ma_ring
    import adc_ma_pkg::*;
(
    input  logic                   clk,
    input  logic                   we,
    input  logic [IDX_BITS-1:0]    wr_addr,
    input  logic [SAMPLE_BITS-1:0] wr_data,
    input  logic                   re,
    input  logic [IDX_BITS-1:0]    rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] mem_reg [WINDOW_MAX];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/adc_ma_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on adc_ma_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

`include "adc_moving_average_unit_macros.svh"

module adc_ma_div
    import adc_ma_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_CNT_BITS-1:0]  count_reg;
    logic [LEN_BITS-1:0]      rem_reg;
    logic [LEN_BITS-1:0]      divisor_reg;
    logic [DIVIDEND_BITS-1:0] quo_reg;

    logic [LEN_BITS:0]        shifted;
    logic                     ge;
    logic [LEN_BITS:0]        diff;
    logic [LEN_BITS-1:0]      rem_next;
    logic [DIVIDEND_BITS-1:0] quo_next;

    // One trial subtraction: bring down the next dividend bit.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        ge       = (shifted >= {1'b0, divisor_reg});
        diff     = shifted - {1'b0, divisor_reg};
        rem_next = ge ? diff[LEN_BITS-1:0] : shifted[LEN_BITS-1:0];
        quo_next = {quo_reg[DIVIDEND_BITS-2:0], ge};
    end

    // Control: count the steps and flag the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= DIV_CNT_BITS'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - DIV_CNT_BITS'(1);
                if (count_reg == DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, divisor and the shifting dividend/quotient word.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
            quo_reg     <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

    `AMA_ASSERT_SAME(a_done_after_busy, done_reg, $past(busy_reg), "divider done without a run")
    `AMA_ASSERT_NEXT(a_start_runs, req.start, busy_reg, "divider did not start")
    `AMA_ASSERT_HOLD(a_rem_below_divisor,
        !busy_reg || divisor_reg == '0 || rem_reg < divisor_reg, "remainder out of range")

endmodule

// ===== rtl/adc_moving_average_unit.sv =====
// Top level of the ADC moving-average unit: sequencer, running sum and output register.
// Depends on adc_ma_pkg, adc_ma_ring, adc_ma_div and the assertion macro header.
//
// Usage:
//   Input channel: sample with in_valid / in_stall. A transaction takes place at a
//   rising edge with in_valid high and in_stall low. in_stall is high while an item
//   is being worked on.
//   Output channel: average (8 fractional bits) and window_full with out_valid /
//   out_stall. A result stays in the output register until its transaction completes.
//   Configuration: cfg_wr_en / cfg_wr_data write window_len (0 acts as 1, values
//   above 64 act as 64) and restart the window. Write only while the unit is idle.
//   Sequence: each item passes from acceptance through one ring read, one sum update,
//   the bit-serial divider, the collection of the quotient and the load of the
//   output register. The next item is taken only after that load; the unit does not
//   work on two items at once.
//   If the receiver stalls, the unit finishes the next item and holds it until the
//   output register frees; no item is dropped.
//   Reset: window_len returns to 16, the sum, index and full flag clear and the
//   output register empties. The ring needs no clearing.
`timescale 1ns / 1ps

`include "adc_moving_average_unit_macros.svh"

module adc_moving_average_unit
    import adc_ma_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_BITS-1:0]    cfg_wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [AVG_BITS-1:0]    average,
    output logic                   window_full
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_UPDATE = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [CFG_BITS-1:0]    window_len_reg;
    logic [IDX_BITS-1:0]    write_index_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic                   filled_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   out_valid_reg;
    logic [AVG_BITS-1:0]    average_reg;
    logic                   window_full_reg;

    logic [LEN_BITS-1:0]    len;
    logic [IDX_BITS-1:0]    cur_idx;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SUM_BITS-1:0]    sum_next;
    logic [LEN_BITS-1:0]    idx_inc;
    logic                   wrap;
    logic                   filled_next;
    logic [IDX_BITS-1:0]    write_index_next;
    logic [LEN_BITS-1:0]    denom;
    logic                   in_take;
    logic                   out_take;
    logic                   out_load;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign in_stall = (state_reg != S_IDLE);

    // Slot for this sample and the arithmetic of the update step.
    always_comb
    begin
        len     = eff_len(window_len_reg);
        cur_idx = ({1'b0, write_index_reg} >= len) ? '0 : write_index_reg;
        old_sample  = filled_reg ? rd_data : '0;
        sum_next    = sum_reg + SUM_BITS'(sample_reg) - SUM_BITS'(old_sample);
        idx_inc     = {1'b0, cur_idx} + LEN_BITS'(1);
        wrap        = (idx_inc == len);
        filled_next = filled_reg || wrap;
        write_index_next = wrap ? '0 : idx_inc[IDX_BITS-1:0];
        denom = filled_next ? len : idx_inc;
        if (denom == '0)
        begin
            denom = LEN_BITS'(1);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_take) state_next = S_READ;
            S_READ:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_DIV;
            S_DIV:    if (div_rsp.done) state_next = S_DONE;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Divider request: the dividend is the new sum with eight fraction bits appended.
    always_comb
    begin
        div_req.start    = (state_reg == S_UPDATE);
        div_req.dividend = {sum_next, {FRAC_BITS{1'b0}}};
        div_req.divisor  = denom;
    end

    // Control state and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            window_len_reg  <= WINDOW_LEN_RESET;
            write_index_reg <= '0;
            sum_reg         <= '0;
            filled_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                window_len_reg  <= cfg_wr_data;
                write_index_reg <= '0;
                sum_reg         <= '0;
                filled_reg      <= 1'b0;
            end
            else if (state_reg == S_UPDATE)
            begin
                write_index_reg <= write_index_next;
                sum_reg         <= sum_next;
                filled_reg      <= filled_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample;
        end
        if (out_load)
        begin
            average_reg     <= div_rsp.quotient[AVG_BITS-1:0];
            window_full_reg <= filled_reg;
        end
    end

    adc_ma_ring u_ring (
        .clk     (clk),
        .we      (state_reg == S_UPDATE),
        .wr_addr (cur_idx),
        .wr_data (sample_reg),
        .re      (state_reg == S_READ),
        .rd_addr (cur_idx),
        .rd_data (rd_data)
    );

    adc_ma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid   = out_valid_reg;
    assign average     = average_reg;
    assign window_full = window_full_reg;

    `AMA_ASSERT_HOLD(a_sum_bound, sum_reg <= SUM_MAX, "running sum above its maximum")
    `AMA_ASSERT_HOLD(a_index_bound, {1'b0, write_index_reg} < len, "write index outside window")
    `AMA_ASSERT_NEXT(a_div_to_done, (state_reg == S_DIV) && div_rsp.done,
        state_reg == S_DONE, "divider result not collected")

endmodule
